### sv/cids_pkg.sv
// Package for the cumulative inner divisor sum core.
// Holds the result width and the status record of the serial units.
// No dependencies.
package cids_pkg;

	localparam int TOTAL_W = 63;

	typedef struct packed {
		logic busy;
		logic done;
	} cids_unit_stat_t;

endpackage

### sv/cids_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on cids_pkg.
module cids_div
	import cids_pkg::*;
#(
	parameter int NW = 31,
	parameter int DW = 17
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NW-1:0]   dividend,
	input  logic [DW-1:0]   divisor,
	output cids_unit_stat_t stat,
	output logic [NW-1:0]   quotient
);

	localparam int CW = (NW > 1) ? $clog2(NW) : 1;

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;
	logic [DW:0]   shifted;
	logic [DW+1:0] trial;
	logic          fit;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dsr_q};
	assign fit     = ~trial[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(NW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], fit};
			rem_q <= fit ? trial[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == CW'(NW - 1));
	assign quotient  = quo_q;

endmodule

### sv/cids_mac.sv
// Bit-serial shift-add multiplier with running sum.
// Per request adds (d*(3i+j) + i + j)/2 with d = j - i. Depends on cids_pkg.
module cids_mac
	import cids_pkg::*;
#(
	parameter int NW = 31,
	parameter int IW = 17
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clear,
	input  logic               start,
	input  logic [IW-1:0]      i_val,
	input  logic [NW-1:0]      j_val,
	output cids_unit_stat_t    stat,
	output logic [TOTAL_W-1:0] acc
);

	localparam int PW = 2 * NW + 1;

	logic               busy_q;
	logic [PW-1:0]      mcand_q;
	logic [NW-1:0]      mplier_q;
	logic [PW-1:0]      prod_q;
	logic [TOTAL_W-1:0] acc_q;
	logic               last;

	assign last = busy_q && (mplier_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			acc_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (last) begin
				busy_q <= 1'b0;
			end
			if (clear) begin
				acc_q <= '0;
			end else if (last) begin
				acc_q <= acc_q + TOTAL_W'(prod_q >> 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= PW'({i_val, 1'b0}) + PW'(i_val) + PW'(j_val);
			mplier_q <= j_val - NW'(i_val);
			prod_q   <= PW'(i_val) + PW'(j_val);
		end else if (busy_q && !last) begin
			if (mplier_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q  <= {mcand_q[PW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[NW-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = last;
	assign acc       = acc_q;

endmodule

### sv/cumulative_inner_divisor_sum_core.sv
// Cumulative inner divisor sum core: for bound n returns the sum over
// k = 2..n of the divisors of k other than 1 and k.
// Depends on cids_pkg, cids_div, cids_mac.
//
// Usage: the request channel (in_valid, in_stall, upper_bound) takes one
// bound; the result channel (out_valid, out_stall, total) returns one sum.
// in_stall stays high while a request is being worked on.
// Pass i runs while i*i <= n; the serial divider forms n/i and the serial
// multiplier folds in the term for i while the divider already works on
// i+1. The divider sets the pace. For n below 4 no pass runs.
// One request at a time.
// The result sits in an output register; a stalled result holds and the
// core waits with the next finished sum until it is taken, while a new
// request is accepted as soon as the sum is in the output register.
// Reset (arst_n low) drops out_valid and returns the core to idle.
module cumulative_inner_divisor_sum_core
	import cids_pkg::*;
#(
	parameter int BOUND_WIDTH = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [BOUND_WIDTH-1:0] upper_bound,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [TOTAL_W-1:0]     total
);

	localparam int IW = (BOUND_WIDTH + 1) / 2 + 1;
	localparam int SW = 2 * IW;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                   st_q;
	logic [BOUND_WIDTH-1:0] n_q;
	logic [IW-1:0]          i_q;
	logic [SW-1:0]          sq_q;
	logic [IW-1:0]          div_i_q;
	logic                   dfull_q;
	logic                   out_valid_q;
	logic [TOTAL_W-1:0]     total_q;

	logic                   in_accept;
	logic                   run;
	logic                   more;
	logic                   div_start;
	logic                   mac_start;
	logic                   finish;
	cids_unit_stat_t        dstat;
	cids_unit_stat_t        mstat;
	logic [BOUND_WIDTH-1:0] quo;
	logic [TOTAL_W-1:0]     macc;

	assign run       = (st_q == ST_RUN);
	assign in_accept = in_valid && (st_q == ST_IDLE);
	assign more      = (sq_q <= SW'(n_q));
	assign div_start = run && more && !dstat.busy && !dfull_q;
	assign mac_start = run && dfull_q && !mstat.busy;
	assign finish    = run && !more && !dstat.busy && !dfull_q && !mstat.busy &&
		(!out_valid_q || !out_stall);

	cids_div #(
		.NW(BOUND_WIDTH),
		.DW(IW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n_q),
		.divisor  (i_q),
		.stat     (dstat),
		.quotient (quo)
	);

	cids_mac #(
		.NW(BOUND_WIDTH),
		.IW(IW)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (in_accept),
		.start  (mac_start),
		.i_val  (div_i_q),
		.j_val  (quo),
		.stat   (mstat),
		.acc    (macc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			dfull_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (finish) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (dstat.done) begin
				dfull_q <= 1'b1;
			end else if (mac_start) begin
				dfull_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			n_q  <= upper_bound;
			i_q  <= IW'(2);
			sq_q <= SW'(4);
		end else if (div_start) begin
			div_i_q <= i_q;
			i_q     <= i_q + IW'(1);
			sq_q    <= sq_q + SW'({i_q, 1'b0}) + SW'(1);
		end
		if (finish) begin
			total_q <= macc;
		end
	end

	assign in_stall  = (st_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign total     = total_q;

`ifndef SYNTHESIS
	a_sq_track: assert property (@(posedge clk) disable iff (!arst_n)
		run |-> (sq_q == SW'(SW'(i_q) * SW'(i_q))))
		else $error("square tracker out of step with i");

	a_div_slot: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.busy |-> !dfull_q)
		else $error("divider running while its quotient is unconsumed");

	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (macc == '0))
		else $error("accumulator not cleared on new request");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (st_q == ST_IDLE) && out_valid_q && (total_q == $past(macc)))
		else $error("finished sum not loaded into output register");
`endif

endmodule
